>>> rtl/obn_pkg.sv
// ============================================================================
// Orthonormal basis package
// Shared types, constants and the Q4.28 to Q1.14 rounding of the frame builder.
// ============================================================================
package obn_pkg;

    localparam int FRAC_OUT  = 14;
    localparam int NORM_ONE  = 16384;
    localparam int NORM_LAT  = 19;
    localparam int CROSS_LAT = 2;
    localparam int V_W       = 33;

    typedef logic signed [15:0] unit_t;

    typedef struct packed {
        unit_t z;
        unit_t y;
        unit_t x;
    } unit_vec_t;

    function automatic unit_t round_q28(input logic signed [V_W-1:0] x);
        logic [V_W-1:0]        mag;
        logic [V_W:0]          sum;
        logic [V_W-FRAC_OUT:0] q;
        logic [FRAC_OUT:0]     qs;
        unit_t                 r;
        mag = x[V_W-1] ? (~x + 1'b1) : x;
        sum = {1'b0, mag} + (V_W+1)'(1 << (FRAC_OUT - 1));
        q   = sum[V_W:FRAC_OUT];
        qs  = (q > (V_W-FRAC_OUT+1)'(NORM_ONE)) ? (FRAC_OUT+1)'(NORM_ONE) : q[FRAC_OUT:0];
        r   = unit_t'({1'b0, qs});
        return x[V_W-1] ? -r : r;
    endfunction

endpackage

>>> rtl/orthonormal_basis_from_two_vectors_top.sv
// ============================================================================
// Orthonormal basis from two vectors
// Throughput: one item per cycle while the skid register is empty, set by the fully pipelined normalizers.
// Reset clears all valid bits; the data registers are not reset.
// Builds w = norm(a), u = norm(cross(b, w)), v = cross(w, u) in Q1.14.
// ============================================================================
module orthonormal_basis_from_two_vectors_top #(
    parameter  int COORD_WIDTH = 16,
    localparam int S_TDATA_W   = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit up, then zero fill.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // w_x, w_y, w_z, u_x, u_y, u_z, v_x, v_y, v_z from the lowest bit up.
    output logic [143:0]         m_axis_tdata,
    // degenerate.
    output logic [1:0]           m_axis_tuser
);

    import obn_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int C_W    = CW + 17;
    localparam int ITEM_W = 146;

    logic en;

    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic [3*CW-1:0]      b_d;

    logic      wn_valid;
    unit_vec_t w_vec;
    logic      w_zero;

    logic                  c_valid;
    logic signed [C_W-1:0] c_x;
    logic signed [C_W-1:0] c_y;
    logic signed [C_W-1:0] c_z;

    logic      un_valid;
    unit_vec_t u_vec;
    logic      u_zero;

    logic [48:0] wf_d21;
    logic [48:0] wf_d23;
    logic [48:0] uf_d2;
    unit_vec_t   w_mid;

    logic                  v_valid;
    logic signed [V_W-1:0] v_x;
    logic signed [V_W-1:0] v_y;
    logic signed [V_W-1:0] v_z;

    logic              rnd_valid_reg;
    logic [ITEM_W-1:0] rnd_data_reg;
    logic              out_valid_reg;
    logic [ITEM_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [ITEM_W-1:0] skid_data_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    assign a_x = signed'(s_axis_tdata[CW-1:0]);
    assign a_y = signed'(s_axis_tdata[2*CW-1:CW]);
    assign a_z = signed'(s_axis_tdata[3*CW-1:2*CW]);

    obn_norm #(.IN_W(CW)) u_norm_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_x      (a_x),
        .in_y      (a_y),
        .in_z      (a_z),
        .out_valid (wn_valid),
        .out_vec   (w_vec),
        .out_zero  (w_zero)
    );

    obn_delay #(.W(3 * CW), .DEPTH(NORM_LAT)) u_dly_b (
        .clk  (clk),
        .en   (en),
        .din  (s_axis_tdata[6*CW-1:3*CW]),
        .dout (b_d)
    );

    obn_cross #(.AW(CW), .BW(16)) u_cross_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wn_valid),
        .a_x       (signed'(b_d[CW-1:0])),
        .a_y       (signed'(b_d[2*CW-1:CW])),
        .a_z       (signed'(b_d[3*CW-1:2*CW])),
        .b_x       (w_vec.x),
        .b_y       (w_vec.y),
        .b_z       (w_vec.z),
        .out_valid (c_valid),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z)
    );

    obn_delay #(.W(49), .DEPTH(CROSS_LAT + NORM_LAT)) u_dly_w (
        .clk  (clk),
        .en   (en),
        .din  ({w_zero, w_vec}),
        .dout (wf_d21)
    );

    obn_norm #(.IN_W(C_W)) u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .in_x      (c_x),
        .in_y      (c_y),
        .in_z      (c_z),
        .out_valid (un_valid),
        .out_vec   (u_vec),
        .out_zero  (u_zero)
    );

    assign w_mid = wf_d21[47:0];

    obn_cross #(.AW(16), .BW(16)) u_cross_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (un_valid),
        .a_x       (w_mid.x),
        .a_y       (w_mid.y),
        .a_z       (w_mid.z),
        .b_x       (u_vec.x),
        .b_y       (u_vec.y),
        .b_z       (u_vec.z),
        .out_valid (v_valid),
        .c_x       (v_x),
        .c_y       (v_y),
        .c_z       (v_z)
    );

    obn_delay #(.W(49), .DEPTH(CROSS_LAT)) u_dly_w2 (
        .clk  (clk),
        .en   (en),
        .din  (wf_d21),
        .dout (wf_d23)
    );

    obn_delay #(.W(49), .DEPTH(CROSS_LAT)) u_dly_u (
        .clk  (clk),
        .en   (en),
        .din  ({u_zero, u_vec}),
        .dout (uf_d2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rnd_valid_reg <= v_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_data_reg <= {uf_d2[48], wf_d23[48], round_q28(v_z), round_q28(v_y),
                             round_q28(v_x), uf_d2[47:0], wf_d23[47:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (out_valid_reg && !m_axis_tready)
            begin
                if (rnd_valid_reg && en)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= rnd_valid_reg && en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (out_valid_reg && !m_axis_tready)
        begin
            if (en)
            begin
                skid_data_reg <= rnd_data_reg;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else
        begin
            out_data_reg <= rnd_data_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg[143:0];
    assign m_axis_tuser  = out_data_reg[145:144];

endmodule

>>> rtl/obn_delay.sv
// ============================================================================
// Delay line
// Holds side data for a fixed number of pipeline advances.
// ============================================================================
module obn_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

>>> rtl/obn_cross.sv
// ============================================================================
// Cross product
// Two stage cross(a, b): products first, then differences.
// ============================================================================
module obn_cross #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [AW-1:0]   a_x,
    input  logic signed [AW-1:0]   a_y,
    input  logic signed [AW-1:0]   a_z,
    input  logic signed [BW-1:0]   b_x,
    input  logic signed [BW-1:0]   b_y,
    input  logic signed [BW-1:0]   b_z,
    output logic                   out_valid,
    output logic signed [AW+BW:0]  c_x,
    output logic signed [AW+BW:0]  c_y,
    output logic signed [AW+BW:0]  c_z
);

    localparam int PW = AW + BW;

    logic                 vld_reg [0:1];
    logic signed [PW-1:0] pr_reg  [0:5];
    logic signed [PW:0]   cx_reg;
    logic signed [PW:0]   cy_reg;
    logic signed [PW:0]   cz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= a_y * b_z;
            pr_reg[1] <= a_z * b_y;
            pr_reg[2] <= a_z * b_x;
            pr_reg[3] <= a_x * b_z;
            pr_reg[4] <= a_x * b_y;
            pr_reg[5] <= a_y * b_x;
            cx_reg    <= (PW+1)'(pr_reg[0]) - (PW+1)'(pr_reg[1]);
            cy_reg    <= (PW+1)'(pr_reg[2]) - (PW+1)'(pr_reg[3]);
            cz_reg    <= (PW+1)'(pr_reg[4]) - (PW+1)'(pr_reg[5]);
        end
    end

    assign out_valid = vld_reg[1];
    assign c_x       = cx_reg;
    assign c_y       = cy_reg;
    assign c_z       = cz_reg;

endmodule

>>> rtl/obn_norm.sv
// ============================================================================
// Vector normalizer
// Magnitudes, range shift, squares and length sum, then one output bit per
// stage of a shift-and-add search for the rounded Q1.14 unit components.
// ============================================================================
module obn_norm #(
    parameter int IN_W = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  in_x,
    input  logic signed [IN_W-1:0]  in_y,
    input  logic signed [IN_W-1:0]  in_z,
    output logic                    out_valid,
    output obn_pkg::unit_vec_t      out_vec,
    output logic                    out_zero
);

    import obn_pkg::*;

    localparam int MW    = (IN_W < 31) ? IN_W : 31;
    localparam int KW_N  = IN_W - MW;
    localparam int SW    = 2 * MW + 2;
    localparam int PW    = SW + FRAC_OUT + 1;
    localparam int YW    = SW + 34;
    localparam int QW    = FRAC_OUT + 1;
    localparam int NSTEP = FRAC_OUT + 1;

    logic            v0_reg;
    logic            v1_reg;
    logic            v2_reg;
    logic [IN_W-1:0] m0_reg   [0:2];
    logic            neg0_reg [0:2];
    logic [MW-1:0]   m1_reg   [0:2];
    logic            neg1_reg [0:2];
    logic            zero1_reg;
    logic [2*MW-1:0] sq_reg   [0:2];
    logic            neg2_reg [0:2];
    logic            zero2_reg;

    logic                 vs_reg   [0:NSTEP-1];
    logic [SW-1:0]        s_reg    [0:NSTEP-1];
    logic                 zs_reg   [0:NSTEP-1];
    logic                 ns_reg   [0:NSTEP-1][0:2];
    logic [QW-1:0]        q_reg    [0:NSTEP-1][0:2];
    logic signed [YW-1:0] y_reg    [0:NSTEP-1][0:2];
    logic [PW-1:0]        p_reg    [0:NSTEP-1][0:2];

    logic      out_valid_reg;
    unit_vec_t out_vec_reg;
    logic      out_zero_reg;

    logic [IN_W-1:0] in_c [0:2];
    logic [IN_W-1:0] or_mag;
    logic [MW-1:0]   m1_next [0:2];

    assign in_c[0] = in_x;
    assign in_c[1] = in_y;
    assign in_c[2] = in_z;
    assign or_mag  = m0_reg[0] | m0_reg[1] | m0_reg[2];

    generate
        if (KW_N == 0)
        begin : g_noshift
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m1_next[i] = m0_reg[i][MW-1:0];
                end
            end
        end
        else
        begin : g_shift
            localparam int KB = $clog2(KW_N + 1);
            logic [KB-1:0]   k;
            logic [IN_W-1:0] sh [0:2];
            always_comb
            begin
                k = '0;
                for (int j = 0; j < KW_N; j++)
                begin
                    if (or_mag[MW+j])
                    begin
                        k = KB'(j + 1);
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    sh[i]      = m0_reg[i] >> k;
                    m1_next[i] = sh[i][MW-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vs_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m0_reg[i]   <= in_c[i][IN_W-1] ? (~in_c[i] + 1'b1) : in_c[i];
                neg0_reg[i] <= in_c[i][IN_W-1];
                m1_reg[i]   <= m1_next[i];
                neg1_reg[i] <= neg0_reg[i];
                sq_reg[i]   <= m1_reg[i] * m1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
                ns_reg[0][i] <= neg2_reg[i];
                q_reg[0][i]  <= '0;
                p_reg[0][i]  <= '0;
                y_reg[0][i]  <= signed'({6'b0, sq_reg[i], 30'b0});
            end
            zero1_reg <= (or_mag == '0);
            zero2_reg <= zero1_reg;
            zs_reg[0] <= zero2_reg;
            s_reg[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        end
    end

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        localparam int B = FRAC_OUT - j;
        logic                 ok     [0:2];
        logic [QW-1:0]        q_next [0:2];
        logic signed [YW-1:0] pe     [0:2];
        logic signed [YW-1:0] se;
        logic signed [YW-1:0] t      [0:2];

        always_comb
        begin
            se = signed'(YW'(s_reg[j]));
            for (int i = 0; i < 3; i++)
            begin
                pe[i]     = signed'(YW'(p_reg[j][i]));
                t[i]      = (pe[i] <<< (B + 3)) - (pe[i] <<< 2) + (se <<< (2 * B + 2))
                            - (se <<< (B + 2)) + se;
                ok[i]     = !q_reg[j][i][FRAC_OUT] && (t[i] <= y_reg[j][i]);
                q_next[i] = ok[i] ? (q_reg[j][i] | (QW'(1) << B)) : q_reg[j][i];
            end
        end

        if (j < NSTEP - 1)
        begin : g_mid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vs_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    vs_reg[j+1] <= vs_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_reg[j+1]  <= s_reg[j];
                    zs_reg[j+1] <= zs_reg[j];
                    for (int i = 0; i < 3; i++)
                    begin
                        ns_reg[j+1][i] <= ns_reg[j][i];
                        q_reg[j+1][i]  <= q_next[i];
                        y_reg[j+1][i]  <= ok[i]
                            ? y_reg[j][i] - ((pe[i] <<< (B + 3)) + (se <<< (2 * B + 2)))
                            : y_reg[j][i];
                        p_reg[j+1][i]  <= ok[i] ? p_reg[j][i] + (PW'(s_reg[j]) << B)
                                                : p_reg[j][i];
                    end
                end
            end
        end
        else
        begin : g_last
            unit_t r [0:2];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r[i] = zs_reg[j] ? '0
                         : (ns_reg[j][i] ? -unit_t'({1'b0, q_next[i]})
                                         : unit_t'({1'b0, q_next[i]}));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    out_valid_reg <= 1'b0;
                end
                else if (en)
                begin
                    out_valid_reg <= vs_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    out_vec_reg.x <= r[0];
                    out_vec_reg.y <= r[1];
                    out_vec_reg.z <= r[2];
                    out_zero_reg  <= zs_reg[j];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_zero  = out_zero_reg;

endmodule
